// ===== rtl/core/gndag_pkg.sv =====
package gndag_pkg;

	localparam int MAX_DEPTH   = 4;
	localparam int EXTENT_BITS = 16;
	localparam int OFFSET_BITS = 32;

	localparam int CNT_W  = 3;   // holds 0..MAX_DEPTH
	localparam int DIM_W  = 2;   // dimension select
	localparam int ROW_W  = 16;
	localparam int CIDX_W = 3;
	localparam int CDAT_W = 4 * EXTENT_BITS;

	typedef enum logic [CIDX_W-1:0] {
		REG_SCATTER = 3'd0,
		REG_ACCUM   = 3'd1,
		REG_BATCH   = 3'd2,
		REG_IPB     = 3'd3,
		REG_ROW     = 3'd4,
		REG_DEPTH   = 3'd5,
		REG_EXTENTS = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic                   scatter_mode;
		logic [OFFSET_BITS-1:0] batch_count;
		logic [OFFSET_BITS-1:0] indices_per_batch;
		logic [ROW_W-1:0]       row_length;
		logic [CNT_W-1:0]       index_depth;
		logic [CDAT_W-1:0]      extents_packed;
	} cfg_t;

	typedef struct packed {
		logic                   en;
		logic [OFFSET_BITS-1:0] a;
		logic [OFFSET_BITS-1:0] b;
		logic [OFFSET_BITS-1:0] c;
	} mac_req_t;

	// 0 acts as 1, anything above MAX_DEPTH clamps
	function automatic logic [CNT_W-1:0] depth_eff(input logic [CNT_W-1:0] d);
		logic [CNT_W-1:0] r;
		r = d;
		if (d == '0)
			r = CNT_W'(1);
		else if (d > CNT_W'(MAX_DEPTH))
			r = CNT_W'(MAX_DEPTH);
		return r;
	endfunction

	function automatic logic [OFFSET_BITS-1:0] ext_of(input logic [CDAT_W-1:0] packed_ext,
			input logic [DIM_W-1:0] h);
		logic [EXTENT_BITS-1:0] e;
		e = packed_ext[h*EXTENT_BITS +: EXTENT_BITS];
		return {{(OFFSET_BITS-EXTENT_BITS){1'b0}}, e};
	endfunction

endpackage

// ===== rtl/core/gather_nd_address_generator_core.sv =====
// Address generator for N-dimensional gather/scatter.
// Item channel (item_valid / item_stall / index_component): one signed index
// component per transfer, outermost dimension first. index_depth transfers
// make one tuple. A component that is negative or not below its extent
// marks the tuple as skipped.
// Command channel (cmd_valid / cmd_stall): one transfer per completed tuple
// with source_offset, dest_offset, skipped, error_seen and job_last.
// Config channel (cfg_valid / cfg_ready): register index plus data; always
// ready. Write only while no tuple is in flight.
// Sequence: a non-final component is accepted, then its partial offset is
// written back. A final component holds the sequencer from its accept
// through the emit step; the command register is loaded in the emit step.
// All steps run through one shared 32x32 multiply-add, one operation per
// cycle (Horner step, depth extent-product steps, then a base
// multiply-add and a row-length scale per offset), plus an emit step.
// The command register decouples the sides: items are accepted while a
// command waits; a stalled receiver only holds the sequencer at its final
// step, so the held command never changes.
// Reset clears the config to defaults, the tuple state and job counters.
module gather_nd_address_generator_core
	import gndag_pkg::*;
(
	input  logic                          clk,
	input  logic                          arst_n,
	// config write channel
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [CIDX_W-1:0]             cfg_index,
	input  logic [CDAT_W-1:0]             cfg_data,
	// index component channel
	input  logic                          item_valid,
	output logic                          item_stall,
	input  logic signed [OFFSET_BITS-1:0] index_component,
	// copy command channel
	output logic                          cmd_valid,
	input  logic                          cmd_stall,
	output logic [OFFSET_BITS-1:0]        source_offset,
	output logic [OFFSET_BITS-1:0]        dest_offset,
	output logic                          skipped,
	output logic                          error_seen,
	output logic                          job_last
);

	cfg_t                   cfg;
	mac_req_t               mac_req;
	logic [OFFSET_BITS-1:0] mac_res;

	// register file
	gndag_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// shared multiply-add, result registered
	gndag_mac u_mac (
		.clk (clk),
		.req (mac_req),
		.res (mac_res)
	);

	// sequencer, tuple/job state and command register
	gndag_seq u_seq (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg),
		.item_valid      (item_valid),
		.item_stall      (item_stall),
		.index_component (index_component),
		.cmd_valid       (cmd_valid),
		.cmd_stall       (cmd_stall),
		.source_offset   (source_offset),
		.dest_offset     (dest_offset),
		.skipped         (skipped),
		.error_seen      (error_seen),
		.job_last        (job_last),
		.mac_req         (mac_req),
		.mac_res         (mac_res)
	);

endmodule

// ===== rtl/core/gndag_cfg.sv =====
module gndag_cfg
	import gndag_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CIDX_W-1:0] cfg_index,
	input  logic [CDAT_W-1:0] cfg_data,
	output cfg_t              cfg
);

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.scatter_mode      <= 1'b0;
			cfg_q.batch_count       <= '0;
			cfg_q.indices_per_batch <= OFFSET_BITS'(1);
			cfg_q.row_length        <= ROW_W'(1);
			cfg_q.index_depth       <= CNT_W'(1);
			cfg_q.extents_packed    <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_SCATTER: cfg_q.scatter_mode      <= cfg_data[0];
				REG_ACCUM:   ;  // add/copy select is consumed by the data mover only
				REG_BATCH:   cfg_q.batch_count       <= cfg_data[OFFSET_BITS-1:0];
				REG_IPB:     cfg_q.indices_per_batch <= cfg_data[OFFSET_BITS-1:0];
				REG_ROW:     cfg_q.row_length        <= cfg_data[ROW_W-1:0];
				REG_DEPTH:   cfg_q.index_depth       <= cfg_data[CNT_W-1:0];
				REG_EXTENTS: cfg_q.extents_packed    <= cfg_data;
				default:     ;
			endcase
		end
	end

endmodule

// ===== rtl/core/gndag_mac.sv =====
module gndag_mac
	import gndag_pkg::*;
(
	input  logic                   clk,
	input  mac_req_t               req,
	output logic [OFFSET_BITS-1:0] res
);

	// a*b + c, low word only
	logic [OFFSET_BITS-1:0] prod_lo;
	logic [OFFSET_BITS-1:0] res_q;

	assign prod_lo = OFFSET_BITS'(req.a * req.b);
	assign res     = res_q;

	always_ff @(posedge clk) begin
		if (req.en)
			res_q <= prod_lo + req.c;
	end

endmodule

// ===== rtl/core/gndag_seq.sv =====
module gndag_seq
	import gndag_pkg::*;
(
	input  logic                          clk,
	input  logic                          arst_n,
	input  cfg_t                          cfg,
	input  logic                          item_valid,
	output logic                          item_stall,
	input  logic signed [OFFSET_BITS-1:0] index_component,
	output logic                          cmd_valid,
	input  logic                          cmd_stall,
	output logic [OFFSET_BITS-1:0]        source_offset,
	output logic [OFFSET_BITS-1:0]        dest_offset,
	output logic                          skipped,
	output logic                          error_seen,
	output logic                          job_last,
	output mac_req_t                      mac_req,
	input  logic [OFFSET_BITS-1:0]        mac_res
);

	typedef enum logic [2:0] {
		S_IDLE, S_PART, S_PROD, S_SRC, S_DST1, S_DST2, S_EMIT
	} state_t;

	state_t                 state_q;
	logic [CNT_W-1:0]       count_q;
	logic [CNT_W-1:0]       idx_q;
	logic [OFFSET_BITS-1:0] partial_q;
	logic [OFFSET_BITS-1:0] src_q;
	logic [OFFSET_BITS-1:0] batch_q;
	logic [OFFSET_BITS-1:0] pos_q;
	logic                   bad_q;
	logic                   final_q;
	logic                   sticky_q;

	logic                   cmd_valid_q;
	logic [OFFSET_BITS-1:0] src_out_q;
	logic [OFFSET_BITS-1:0] dst_out_q;
	logic                   skip_out_q;
	logic                   err_out_q;
	logic                   last_out_q;

	logic [CNT_W-1:0]       depth;
	logic [CNT_W-1:0]       h_full;
	logic [CNT_W-1:0]       h_next;
	logic [OFFSET_BITS-1:0] ext_h;
	logic [OFFSET_BITS-1:0] raw_u;
	logic                   comp_bad;
	logic                   item_fire;
	logic                   emit_ok;
	logic                   load_cmd;
	logic                   last_pos;
	logic                   last_batch;
	logic                   last_tuple;
	logic [OFFSET_BITS-1:0] row_ext;
	logic [OFFSET_BITS-1:0] src_sel;
	logic [OFFSET_BITS-1:0] dst_sel;

	assign depth     = depth_eff(cfg.index_depth);
	assign h_full    = (count_q >= depth) ? depth - CNT_W'(1) : count_q;
	assign h_next    = h_full + CNT_W'(1);
	assign ext_h     = ext_of(cfg.extents_packed, h_full[DIM_W-1:0]);
	assign raw_u     = $unsigned(index_component);
	// sign bit set means raw_u >= 2^31, above any extent
	assign comp_bad  = raw_u >= ext_h;
	assign item_stall = (state_q != S_IDLE);
	assign item_fire = item_valid && !item_stall;
	assign emit_ok   = !cmd_valid_q || !cmd_stall;
	assign load_cmd  = (state_q == S_EMIT) && emit_ok;
	assign row_ext   = {{(OFFSET_BITS-ROW_W){1'b0}}, cfg.row_length};

	assign last_pos   = ({1'b0, pos_q} + {{OFFSET_BITS{1'b0}}, 1'b1})
			>= {1'b0, cfg.indices_per_batch};
	assign last_batch = ({1'b0, batch_q} + {{OFFSET_BITS{1'b0}}, 1'b1})
			>= {1'b0, cfg.batch_count};
	assign last_tuple = last_pos && last_batch;

	// mac_res holds dest offset in S_EMIT
	assign src_sel = bad_q ? '0 : (cfg.scatter_mode ? mac_res : src_q);
	assign dst_sel = bad_q ? '0 : (cfg.scatter_mode ? src_q : mac_res);

	always_comb begin
		mac_req = '0;
		unique case (state_q)
			S_IDLE: begin
				mac_req.en = item_fire;
				mac_req.a  = partial_q;
				mac_req.b  = ext_h;
				mac_req.c  = raw_u;
			end
			S_PART: begin
				// extent product seed: 1 * ext0
				mac_req.en = final_q;
				mac_req.a  = OFFSET_BITS'(1);
				mac_req.b  = ext_of(cfg.extents_packed, DIM_W'(0));
			end
			S_PROD: begin
				mac_req.en = 1'b1;
				if (idx_q < depth) begin
					mac_req.a = mac_res;
					mac_req.b = ext_of(cfg.extents_packed, idx_q[DIM_W-1:0]);
				end else begin
					mac_req.a = batch_q;
					mac_req.b = mac_res;
					mac_req.c = partial_q;
				end
			end
			S_SRC: begin
				mac_req.en = 1'b1;
				mac_req.a  = mac_res;
				mac_req.b  = row_ext;
			end
			S_DST1: begin
				mac_req.en = 1'b1;
				mac_req.a  = batch_q;
				mac_req.b  = cfg.indices_per_batch;
				mac_req.c  = pos_q;
			end
			S_DST2: begin
				mac_req.en = 1'b1;
				mac_req.a  = mac_res;
				mac_req.b  = row_ext;
			end
			S_EMIT: mac_req.en = 1'b0;
			default: mac_req.en = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			idx_q       <= '0;
			partial_q   <= '0;
			src_q       <= '0;
			batch_q     <= '0;
			pos_q       <= '0;
			bad_q       <= 1'b0;
			final_q     <= 1'b0;
			sticky_q    <= 1'b0;
			cmd_valid_q <= 1'b0;
			src_out_q   <= '0;
			dst_out_q   <= '0;
			skip_out_q  <= 1'b0;
			err_out_q   <= 1'b0;
			last_out_q  <= 1'b0;
		end else begin
			if (load_cmd)
				cmd_valid_q <= 1'b1;
			else if (cmd_valid_q && !cmd_stall)
				cmd_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (item_fire) begin
						bad_q   <= bad_q | comp_bad;
						final_q <= (h_next == depth);
						count_q <= (h_next == depth) ? '0 : h_next;
						state_q <= S_PART;
					end
				end
				S_PART: begin
					partial_q <= mac_res;
					idx_q     <= CNT_W'(1);
					state_q   <= final_q ? S_PROD : S_IDLE;
				end
				S_PROD: begin
					if (idx_q < depth)
						idx_q <= idx_q + CNT_W'(1);
					else
						state_q <= S_SRC;
				end
				S_SRC: state_q <= S_DST1;
				S_DST1: begin
					src_q   <= mac_res;
					state_q <= S_DST2;
				end
				S_DST2: state_q <= S_EMIT;
				S_EMIT: begin
					if (emit_ok) begin
						src_out_q   <= src_sel;
						dst_out_q   <= dst_sel;
						skip_out_q  <= bad_q;
						err_out_q   <= sticky_q | bad_q;
						last_out_q  <= last_tuple;
						partial_q   <= '0;
						bad_q       <= 1'b0;
						final_q     <= 1'b0;
						if (last_tuple) begin
							batch_q  <= '0;
							pos_q    <= '0;
							sticky_q <= 1'b0;
						end else begin
							sticky_q <= sticky_q | bad_q;
							if (last_pos) begin
								pos_q   <= '0;
								batch_q <= batch_q + OFFSET_BITS'(1);
							end else begin
								pos_q <= pos_q + OFFSET_BITS'(1);
							end
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign cmd_valid     = cmd_valid_q;
	assign source_offset = src_out_q;
	assign dest_offset   = dst_out_q;
	assign skipped       = skip_out_q;
	assign error_seen    = err_out_q;
	assign job_last      = last_out_q;

	a_rise_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(cmd_valid_q) |-> $past(state_q == S_EMIT))
		else $error("command appeared outside emit step");

	a_skip_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid_q && skip_out_q) |->
			(src_out_q == '0 && dst_out_q == '0 && err_out_q))
		else $error("skipped command carries offsets or lacks error flag");

	a_job_end_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT && emit_ok && last_tuple) |=>
			(batch_q == '0 && pos_q == '0 && !sticky_q))
		else $error("job counters not cleared after last tuple");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q < CNT_W'(MAX_DEPTH))
		else $error("component count out of range");

endmodule
